>>> rtl/slfc_pkg.sv
`default_nettype none
package slfc_pkg;

	// sync pair and control frame constants
	localparam logic [7:0] SYNC_FIRST     = 8'hFE;
	localparam logic [7:0] SYNC_SECOND    = 8'hFF;
	localparam logic [7:0] RESET_FLAGS    = 8'h11;
	localparam logic [7:0] CONTROL_SIZE   = 8'h00;
	localparam int         CONTROL_LENGTH = 8;

	// result kinds
	localparam logic [1:0] KIND_RESET = 2'd0;
	localparam logic [1:0] KIND_DELAY = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic take;
		logic load_ctrl;
		logic load_word;
		logic rd_en;
		logic row_clr;
		logic row_inc;
	} slfc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic ctrl_done;
		logic frame_done;
		logic out_free;
		logic last_row;
	} slfc_stat_t;

endpackage
`default_nettype wire

>>> rtl/slfc_datapath.sv
`default_nettype none
module slfc_datapath import slfc_pkg::*; #(
	parameter int STORE_DEPTH = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire slfc_cmd_t  cmd,
	output slfc_stat_t      stat,
	input  wire logic       out_stall,
	output logic            out_valid,
	output logic [1:0]      event_kind,
	output logic [7:0]      read_delay,
	output logic [7:0]      write_delay,
	output logic [7:0]      lane_zero,
	output logic [7:0]      lane_one,
	output logic [7:0]      lane_two,
	output logic [7:0]      lane_three,
	output logic [2:0]      byte_count,
	output logic            last_word
);

	localparam int FW   = $clog2(STORE_DEPTH + 3);
	localparam int ROWS = (STORE_DEPTH + 3) / 4;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW   = (FW > 8) ? FW : 8;
	localparam logic [FW-1:0] FULL_COUNT = FW'(STORE_DEPTH + 2);

	logic [FW-1:0] fill_q, fill_d, idx, nxt;
	logic [RW-1:0] wrow, row_q;
	logic [7:0]    size_q, flags_q, rdelay_q, wdelay_q;
	logic [7:0]    size_now, size_m1;
	logic          store_en, ctrl_hit, frame_hit;
	logic [2:0]    cnt;
	logic [7:0]    rdata_q [4];

	logic          out_valid_q, last_q;
	logic [1:0]    kind_q;
	logic [7:0]    rd_q, wr_q;
	logic [7:0]    lane_q [4];
	logic [2:0]    cnt_q;

	// frame tracking for the incoming byte
	always_comb begin
		idx       = fill_q - FW'(2);
		nxt       = fill_q + FW'(1);
		wrow      = RW'(idx >> 2);
		size_now  = (idx == '0) ? data_byte : size_q;
		ctrl_hit  = (CW'(nxt) == CW'(CONTROL_LENGTH)) && (size_now == CONTROL_SIZE);
		frame_hit = (CW'(nxt) > CW'(3)) && (size_now != 8'h00)
			&& ((CW'(nxt) - CW'(2)) == CW'(size_now));
		store_en  = 1'b0;
		fill_d    = fill_q;
		if (fill_q >= FULL_COUNT) begin
			fill_d = fill_q;
		end else if (fill_q == FW'(0)) begin
			if (data_byte == SYNC_FIRST) begin
				fill_d = FW'(1);
			end
		end else if (fill_q == FW'(1)) begin
			fill_d = (data_byte == SYNC_SECOND) ? FW'(2) : FW'(0);
		end else begin
			store_en = 1'b1;
			fill_d   = (ctrl_hit || frame_hit) ? FW'(0) : nxt;
		end
	end

	// word lane count
	always_comb begin
		size_m1 = size_q - 8'd1;
		stat.last_row = (size_m1[7:2] == 6'(row_q));
		cnt = stat.last_row ? ({1'b0, size_m1[1:0]} + 3'd1) : 3'd4;
		stat.ctrl_done  = store_en && ctrl_hit;
		stat.frame_done = store_en && frame_hit;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				fill_q <= fill_d;
			end
			if (cmd.row_clr) begin
				row_q <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_q + RW'(1);
			end
			if (cmd.load_ctrl || cmd.load_word) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// header bytes kept aside
	always_ff @(posedge clk) begin
		if (cmd.take && store_en) begin
			if (idx == FW'(0)) begin
				size_q <= data_byte;
			end else if (idx == FW'(1)) begin
				flags_q <= data_byte;
			end else if (idx == FW'(2)) begin
				rdelay_q <= data_byte;
			end else if (idx == FW'(3)) begin
				wdelay_q <= data_byte;
			end
		end
	end

	// frame store, one bank per byte lane
	for (genvar j = 0; j < 4; j++) begin : g_lane
		logic [7:0] mem [ROWS];
		always_ff @(posedge clk) begin
			if (cmd.take && store_en && (idx[1:0] == 2'(j))) begin
				mem[wrow] <= data_byte;
			end
			if (cmd.rd_en) begin
				rdata_q[j] <= mem[row_q];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_ctrl) begin
			kind_q <= (flags_q == RESET_FLAGS) ? KIND_RESET : KIND_DELAY;
			rd_q   <= (flags_q == RESET_FLAGS) ? 8'h00 : rdelay_q;
			wr_q   <= (flags_q == RESET_FLAGS) ? 8'h00 : wdelay_q;
			for (int j = 0; j < 4; j++) begin
				lane_q[j] <= 8'h00;
			end
			cnt_q  <= 3'd0;
			last_q <= 1'b0;
		end else if (cmd.load_word) begin
			kind_q <= KIND_FRAME;
			rd_q   <= 8'h00;
			wr_q   <= 8'h00;
			for (int j = 0; j < 4; j++) begin
				lane_q[j] <= (3'(j) < cnt) ? rdata_q[j] : 8'h00;
			end
			cnt_q  <= cnt;
			last_q <= stat.last_row;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = kind_q;
	assign read_delay  = rd_q;
	assign write_delay = wr_q;
	assign lane_zero   = lane_q[0];
	assign lane_one    = lane_q[1];
	assign lane_two    = lane_q[2];
	assign lane_three  = lane_q[3];
	assign byte_count  = cnt_q;
	assign last_word   = last_q;

endmodule
`default_nettype wire

>>> rtl/slfc_ctrl.sv
`default_nettype none
module slfc_ctrl import slfc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire slfc_stat_t stat,
	output slfc_cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_COLLECT,
		S_CTRL,
		S_READ,
		S_LOAD
	} state_t;

	state_t state_q;

	// commands from the current state
	always_comb begin
		cmd           = '0;
		in_stall      = (state_q != S_COLLECT);
		cmd.take      = in_valid && (state_q == S_COLLECT);
		cmd.row_clr   = cmd.take && stat.frame_done;
		cmd.rd_en     = (state_q == S_READ);
		cmd.load_ctrl = (state_q == S_CTRL) && stat.out_free;
		cmd.load_word = (state_q == S_LOAD) && stat.out_free;
		cmd.row_inc   = cmd.load_word && !stat.last_row;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
		end else begin
			case (state_q)
				S_COLLECT: begin
					if (cmd.take && stat.ctrl_done) begin
						state_q <= S_CTRL;
					end else if (cmd.take && stat.frame_done) begin
						state_q <= S_READ;
					end
				end
				S_CTRL: begin
					if (stat.out_free) begin
						state_q <= S_COLLECT;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (stat.out_free) begin
						state_q <= stat.last_row ? S_COLLECT : S_READ;
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/sync_length_frame_collector.sv
// Bytes are taken one per cycle while collecting; a byte that ends no frame does not stall.
// After a control frame, the control state loads its result once the output is free.
// A data frame is read from the four-bank lane store one row per word: the read state
// registers the row and the load state then loads the word into the output register;
// the input stays stalled until the last word is loaded, which waits on output stalls.
// Reset clears the byte counter, sequencer and output valid; the store needs no clearing.
`default_nettype none
module sync_length_frame_collector import slfc_pkg::*; #(
	parameter int STORE_DEPTH = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      event_kind,
	output logic [7:0]      read_delay,
	output logic [7:0]      write_delay,
	output logic [7:0]      lane_zero,
	output logic [7:0]      lane_one,
	output logic [7:0]      lane_two,
	output logic [7:0]      lane_three,
	output logic [2:0]      byte_count,
	output logic            last_word
);

	slfc_cmd_t  cmd;
	slfc_stat_t stat;

	// sequencer
	slfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// counter, store and output register
	slfc_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.event_kind  (event_kind),
		.read_delay  (read_delay),
		.write_delay (write_delay),
		.lane_zero   (lane_zero),
		.lane_one    (lane_one),
		.lane_two    (lane_two),
		.lane_three  (lane_three),
		.byte_count  (byte_count),
		.last_word   (last_word)
	);

endmodule
`default_nettype wire
